FILE: hw/rtl/cbez_pkg.sv
// ----------------------------------------------------------------------------
// cbez_pkg
// Types, widths and constants shared by the cubic Bezier evaluator.
// ----------------------------------------------------------------------------
package cbez_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int T_W       = FRAC_BITS + 1;
  // (b - a) is one bit wider than a coordinate; t is made signed by a zero bit.
  localparam int PROD_W    = COORD_W + 1 + T_W + 1;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 2;
  // Input register plus two stages for each of the three interpolation levels.
  localparam int PIPE_DEPTH = 7;

  localparam logic [T_W-1:0]           T_ONE = T_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [IDX_W-1:0]         LAST_IDX = IDX_W'(3);

  typedef enum logic [2:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } cbez_reg_e;

  typedef enum logic {
    KIND_EVAL  = 1'b0,
    KIND_SPLIT = 1'b1
  } cbez_kind_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } cbez_pt_t;

  typedef struct packed {
    logic           kind;
    logic [T_W-1:0] param_t;
  } cbez_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic [IDX_W-1:0]          point_index;
    logic                      last;
  } cbez_out_t;

  // Everything the output sequencer needs from one finished item.
  typedef struct packed {
    logic     kind;
    cbez_pt_t p0;
    cbez_pt_t p01;
    cbez_pt_t p012;
    cbez_pt_t p0123;
  } cbez_result_t;

endpackage

FILE: hw/rtl/cubic_bezier_eval_split.sv
// ----------------------------------------------------------------------------
// cubic_bezier_eval_split
// Fixed-point de Casteljau evaluation and left-half split of a cubic curve.
// ----------------------------------------------------------------------------
// The four control points are written through the APB port (x then y for
// P0..P3 at byte addresses 0x00..0x1C, signed Q16.16); the user must write
// them only while the block is idle, which the block does not enforce.
// Each input transaction carries kind and param_t (unsigned Q1.16, values
// above 1.0 are clamped to 1.0). An evaluate item produces one result
// transaction, the curve point at t, with point_index 0 and last set. A split
// item produces four transactions, P0, P01, P012 and P0123 of the left
// sub-curve, with last on the fourth. The first result is registered in an input
// register, two registers per de Casteljau level and the output register.
// The block takes one evaluate item per cycle while the receiver is ready; a
// split item holds the output for its four transactions, sequenced by the
// single result register. When the receiver stalls, the whole pipeline
// holds; in_ready drops once the output register is occupied and cannot drain
// this cycle. Reset clears all valid bits and the control points to zero.
// ----------------------------------------------------------------------------
module cubic_bezier_eval_split (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cbez_pkg::cbez_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cbez_pkg::cbez_out_t              out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cbez_pkg::ADDR_W-1:0]      paddr,
  input  logic [cbez_pkg::DATA_W-1:0]      pwdata,
  output logic [cbez_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);
  import cbez_pkg::*;

  cbez_pt_t     p0, p1, p2, p3;
  cbez_reg_e    reg_sel;
  logic         advance;
  logic         valid   [PIPE_DEPTH];
  logic         kind_d  [PIPE_DEPTH];
  logic [T_W-1:0] t_d   [5];
  cbez_pt_t     p01_d   [4];
  cbez_pt_t     p012_d  [2];
  cbez_pt_t     p01, p12, p23, p012, p123, p0123;
  logic [T_W-1:0] t_sat;
  cbez_result_t result;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_sel = cbez_reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      p0 <= '0;
      p1 <= '0;
      p2 <= '0;
      p3 <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_P0_X: p0.x <= pwdata;
        REG_P0_Y: p0.y <= pwdata;
        REG_P1_X: p1.x <= pwdata;
        REG_P1_Y: p1.y <= pwdata;
        REG_P2_X: p2.x <= pwdata;
        REG_P2_Y: p2.y <= pwdata;
        REG_P3_X: p3.x <= pwdata;
        REG_P3_Y: p3.y <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_P0_X: prdata = p0.x;
      REG_P0_Y: prdata = p0.y;
      REG_P1_X: prdata = p1.x;
      REG_P1_Y: prdata = p1.y;
      REG_P2_X: prdata = p2.x;
      REG_P2_Y: prdata = p2.y;
      REG_P3_X: prdata = p3.x;
      REG_P3_Y: prdata = p3.y;
    endcase
  end

  // Pipeline control: every stage moves together when the output can take.
  assign in_ready = advance;
  assign t_sat    = (in_data.param_t > T_ONE) ? T_ONE : in_data.param_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (advance) begin
      valid[0] <= in_valid;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        valid[i] <= valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_d[0] <= in_data.kind;
      t_d[0]    <= t_sat;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        kind_d[i] <= kind_d[i-1];
      end
      for (int i = 1; i < 5; i++) begin
        t_d[i] <= t_d[i-1];
      end
      p01_d[0]  <= p01;
      for (int i = 1; i < 4; i++) begin
        p01_d[i] <= p01_d[i-1];
      end
      p012_d[0] <= p012;
      p012_d[1] <= p012_d[0];
    end
  end

  // Level one: the user keeps control points stable while items are in flight.
  cbez_lerp u_l1_a (.clk(clk), .en(advance), .a(p0), .b(p1), .t(t_d[0]), .res(p01));
  cbez_lerp u_l1_b (.clk(clk), .en(advance), .a(p1), .b(p2), .t(t_d[0]), .res(p12));
  cbez_lerp u_l1_c (.clk(clk), .en(advance), .a(p2), .b(p3), .t(t_d[0]), .res(p23));

  cbez_lerp u_l2_a (.clk(clk), .en(advance), .a(p01), .b(p12), .t(t_d[2]), .res(p012));
  cbez_lerp u_l2_b (.clk(clk), .en(advance), .a(p12), .b(p23), .t(t_d[2]), .res(p123));

  cbez_lerp u_l3 (.clk(clk), .en(advance), .a(p012), .b(p123), .t(t_d[4]), .res(p0123));

  assign result.kind  = kind_d[PIPE_DEPTH-1];
  assign result.p0    = p0;
  assign result.p01   = p01_d[3];
  assign result.p012  = p012_d[1];
  assign result.p0123 = p0123;

  cbez_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (valid[PIPE_DEPTH-1]),
    .load_data  (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: hw/rtl/cbez_lerp.sv
// ----------------------------------------------------------------------------
// cbez_lerp
// Two-stage linear interpolation of a 2-D point: multiply, then round and add.
// ----------------------------------------------------------------------------
module cbez_lerp (
  input  logic                    clk,
  input  logic                    en,
  input  cbez_pkg::cbez_pt_t      a,
  input  cbez_pkg::cbez_pt_t      b,
  input  logic [cbez_pkg::T_W-1:0] t,
  output cbez_pkg::cbez_pt_t      res
);
  import cbez_pkg::*;

  logic signed [COORD_W:0]   diff_x, diff_y;
  logic signed [PROD_W-1:0]  prod_x, prod_y;
  logic signed [PROD_W-1:0]  sum_x, sum_y;
  cbez_pt_t                  a_q;
  cbez_pt_t                  res_next;

  assign diff_x = {b.x[COORD_W-1], b.x} - {a.x[COORD_W-1], a.x};
  assign diff_y = {b.y[COORD_W-1], b.y} - {a.y[COORD_W-1], a.y};

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= diff_x * $signed({1'b0, t});
      prod_y <= diff_y * $signed({1'b0, t});
      a_q    <= a;
    end
  end

  // Adding one half before the arithmetic shift rounds half up.
  assign sum_x = prod_x + ROUND_HALF;
  assign sum_y = prod_y + ROUND_HALF;
  assign res_next.x = a_q.x + sum_x[FRAC_BITS +: COORD_W];
  assign res_next.y = a_q.y + sum_y[FRAC_BITS +: COORD_W];

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

FILE: hw/rtl/cbez_out_stage.sv
// ----------------------------------------------------------------------------
// cbez_out_stage
// Holds one finished item and sends its one or four result transactions.
// ----------------------------------------------------------------------------
module cbez_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load_valid,
  input  cbez_pkg::cbez_result_t load_data,
  output logic                   advance,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cbez_pkg::cbez_out_t    out_data
);
  import cbez_pkg::*;

  logic             busy;
  logic [IDX_W-1:0] idx;
  cbez_result_t     held;
  logic             last_now;

  assign last_now  = (held.kind == KIND_EVAL) || (idx == LAST_IDX);
  assign advance   = !busy || (out_ready && last_now);
  assign out_valid = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (advance) begin
      busy <= load_valid;
      idx  <= '0;
    end else if (out_ready) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      held <= load_data;
    end
  end

  always_comb begin
    out_data.point_index = idx;
    out_data.last        = last_now;
    if (held.kind == KIND_EVAL) begin
      out_data.out_x = held.p0123.x;
      out_data.out_y = held.p0123.y;
    end else begin
      unique case (idx)
        2'd0: begin
          out_data.out_x = held.p0.x;
          out_data.out_y = held.p0.y;
        end
        2'd1: begin
          out_data.out_x = held.p01.x;
          out_data.out_y = held.p01.y;
        end
        2'd2: begin
          out_data.out_x = held.p012.x;
          out_data.out_y = held.p012.y;
        end
        default: begin
          out_data.out_x = held.p0123.x;
          out_data.out_y = held.p0123.y;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/cbez_checker.sv
// ----------------------------------------------------------------------------
// cbez_checker
// Port-level checks on the result channel of the cubic Bezier evaluator.
// ----------------------------------------------------------------------------
module cbez_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                out_valid,
  input  logic                out_ready,
  input  cbez_pkg::cbez_out_t out_data
);
  import cbez_pkg::*;

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // A split sequence continues without a gap and in index order.
  a_split_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last |=>
      out_valid && (out_data.point_index == $past(out_data.point_index) + IDX_W'(1)))
    else $error("split sequence broken");

  // The fourth control point always closes the item.
  a_idx_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.point_index == LAST_IDX) |-> out_data.last)
    else $error("last missing on final control point");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind cubic_bezier_eval_split cbez_checker u_cbez_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: sim/cubic_bezier_eval_split_tb.sv
// ----------------------------------------------------------------------------
// cubic_bezier_eval_split_tb
// Self-checking bench for the fixed-point cubic Bezier evaluator and splitter.
// ----------------------------------------------------------------------------
// Control points are loaded over APB, each write followed by a read back.
// Every accepted parameter is run through a de Casteljau calculation in the
// bench, and the expected points are queued in order. Each result transaction
// is compared field by field with the oldest queued point. A directed part
// covers the t extremes, saturation above 1.0, rounding ties and full-range
// control points. Random batches follow under several control point sets and
// several patterns of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module cubic_bezier_eval_split_tb;
  import cbez_pkg::*;

  // Holds the control points and the queue of points the block owes us.
  class ctrl_point_ledger;
    logic signed [COORD_W-1:0] ctrl_regs [8];
    cbez_out_t                 owed_points [$];
    int                        mismatches;
    int                        points_checked;

    function new();
      foreach (ctrl_regs[i]) ctrl_regs[i] = '0;
      mismatches = 0;
      points_checked = 0;
    endfunction

    function void set_reg(cbez_reg_e r, logic [DATA_W-1:0] v);
      ctrl_regs[int'(r)] = v;
    endfunction

    function cbez_pt_t ctrl_pt(int k);
      cbez_pt_t p;
      p.x = ctrl_regs[2*k];
      p.y = ctrl_regs[2*k+1];
      return p;
    endfunction

    // a + (b - a) * t, scaled back by 2^FRAC_BITS, rounded half up.
    // The arithmetic shift of a signed value is a floor, which is what we want.
    function longint lerp_coord(longint a, longint b, longint t);
      longint prod;
      prod = (b - a) * t + (longint'(1) <<< (FRAC_BITS - 1));
      return a + (prod >>> FRAC_BITS);
    endfunction

    function cbez_pt_t lerp_pt(cbez_pt_t a, cbez_pt_t b, longint t);
      cbez_pt_t r;
      r.x = COORD_W'(lerp_coord(longint'(a.x), longint'(b.x), t));
      r.y = COORD_W'(lerp_coord(longint'(a.y), longint'(b.y), t));
      return r;
    endfunction

    function void owe_point(cbez_pt_t p, int idx, logic is_last);
      cbez_out_t o;
      o.out_x = p.x;
      o.out_y = p.y;
      o.point_index = IDX_W'(idx);
      o.last = is_last;
      owed_points.insert(owed_points.size(), o);
    endfunction

    function void note_param(cbez_in_t item);
      longint   t;
      cbez_pt_t p0, p1, p2, p3, p01, p12, p23, p012, p123, p0123;
      t = longint'(item.param_t);
      if (t > longint'(T_ONE)) t = longint'(T_ONE);
      p0 = ctrl_pt(0);
      p1 = ctrl_pt(1);
      p2 = ctrl_pt(2);
      p3 = ctrl_pt(3);
      p01 = lerp_pt(p0, p1, t);
      p12 = lerp_pt(p1, p2, t);
      p23 = lerp_pt(p2, p3, t);
      p012 = lerp_pt(p01, p12, t);
      p123 = lerp_pt(p12, p23, t);
      p0123 = lerp_pt(p012, p123, t);
      if (item.kind == KIND_SPLIT) begin
        owe_point(p0, 0, 1'b0);
        owe_point(p01, 1, 1'b0);
        owe_point(p012, 2, 1'b0);
        owe_point(p0123, int'(LAST_IDX), 1'b1);
      end else begin
        owe_point(p0123, 0, 1'b1);
      end
    endfunction

    function void check_point(cbez_out_t got);
      cbez_out_t want;
      points_checked++;
      if (owed_points.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result x=%0d y=%0d idx=%0d last=%0b",
                 $time, got.out_x, got.out_y, got.point_index, got.last);
        return;
      end
      want = owed_points.pop_front();
      if (got.out_x !== want.out_x) begin
        mismatches++;
        $display("%0t: out_x expected %0d got %0d", $time, want.out_x, got.out_x);
      end
      if (got.out_y !== want.out_y) begin
        mismatches++;
        $display("%0t: out_y expected %0d got %0d", $time, want.out_y, got.out_y);
      end
      if (got.point_index !== want.point_index) begin
        mismatches++;
        $display("%0t: point_index expected %0d got %0d", $time,
                 want.point_index, got.point_index);
      end
      if (got.last !== want.last) begin
        mismatches++;
        $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
      end
    endfunction

    function void check_reg(cbez_reg_e r, logic [DATA_W-1:0] got);
      if (got !== DATA_W'(ctrl_regs[int'(r)])) begin
        mismatches++;
        $display("%0t: read of %s expected %h got %h", $time, r.name(),
                 ctrl_regs[int'(r)], got);
      end
    endfunction

    function int pending();
      return owed_points.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  cbez_in_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cbez_out_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  ctrl_point_ledger   ledger;
  int unsigned        stall_pct = 0;
  int                 n_eval = 0;
  int                 n_split = 0;
  int                 n_point_sets = 0;

  cubic_bezier_eval_split u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Result side: check each transaction, then pick next cycle's ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) ledger.check_point(out_data);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(cbez_reg_e r, logic [DATA_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ledger.set_reg(r, v);
    // Back-to-back read of the same register.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ledger.check_reg(r, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_points(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                             logic [31:0] y1, logic [31:0] x2, logic [31:0] y2,
                             logic [31:0] x3, logic [31:0] y3);
    write_reg(REG_P0_X, x0);
    write_reg(REG_P0_Y, y0);
    write_reg(REG_P1_X, x1);
    write_reg(REG_P1_Y, y1);
    write_reg(REG_P2_X, x2);
    write_reg(REG_P2_Y, y2);
    write_reg(REG_P3_X, x3);
    write_reg(REG_P3_Y, y3);
    n_point_sets++;
  endtask

  task automatic send_param(cbez_kind_e k, int unsigned t, int unsigned idle_pct);
    int unsigned gap;
    cbez_in_t    item;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 20) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.kind = k;
    item.param_t = T_W'(t);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    ledger.note_param(item);
    if (k == KIND_SPLIT) n_split++;
    else n_eval++;
  endtask

  task automatic send_random(int unsigned idle_pct);
    int unsigned sel;
    int unsigned t;
    sel = $urandom_range(9);
    case (sel)
      0: t = 0;
      1: t = 32'h1_0000;
      2: t = $urandom_range(131071, 65537);
      default: t = $urandom_range(65536, 0);
    endcase
    send_param(cbez_kind_e'($urandom_range(1)), t, idle_pct);
  endtask

  // Let every owed point come back and the pipeline empty out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [31:0] near_coord();
    return 32'(int'($urandom_range(2097152)) - 1048576);
  endfunction

  task automatic random_batch(int unsigned idle_pct, int unsigned stall);
    stall_pct = stall;
    repeat (26) send_random(idle_pct);
    wait_drained();
  endtask

  initial begin
    ledger = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Points still at their reset value of zero.
    send_param(KIND_EVAL, 32768, 0);
    send_param(KIND_SPLIT, 65536, 0);
    wait_drained();

    // Odd coordinate differences of both signs, so t = 0.5 lands on ties.
    load_points(32'hFFFC_8001, 32'h0001_4000, 32'h0002_0007, 32'hFFFF_0003,
                32'h0005_8000, 32'h0003_0005, 32'hFFFE_0001, 32'hFFF8_8000);
    send_param(KIND_EVAL, 0, 0);
    send_param(KIND_EVAL, 65536, 0);
    send_param(KIND_EVAL, 32768, 0);
    send_param(KIND_EVAL, 1, 0);
    send_param(KIND_EVAL, 65535, 0);
    send_param(KIND_EVAL, 65537, 0);
    send_param(KIND_EVAL, 131071, 0);
    send_param(KIND_SPLIT, 0, 0);
    send_param(KIND_SPLIT, 32768, 0);
    send_param(KIND_SPLIT, 65536, 0);
    send_param(KIND_SPLIT, 98304, 0);
    send_param(KIND_SPLIT, 21845, 0);
    wait_drained();

    // Full-scale swings between the most negative and most positive values.
    stall_pct = 31;
    load_points(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_param(KIND_EVAL, 32768, 31);
    send_param(KIND_EVAL, 1, 31);
    send_param(KIND_SPLIT, 65535, 31);
    send_param(KIND_SPLIT, 32768, 31);
    send_param(KIND_EVAL, 131071, 31);
    send_param(KIND_SPLIT, 43690, 31);
    wait_drained();

    load_points($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
    random_batch(0, 0);

    load_points(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    random_batch(48, 0);

    load_points(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    random_batch(0, 48);

    load_points(near_coord(), near_coord(), near_coord(), near_coord(),
                near_coord(), near_coord(), near_coord(), near_coord());
    random_batch(31, 31);

    load_points($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
    random_batch(48, 48);

    $display("Ran %0d evaluate and %0d split transactions over %0d control point sets,",
             n_eval, n_split, n_point_sets);
    $display("with %0d result transactions checked under mixed idle and stall patterns.",
             ledger.points_checked);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
